@@ rtl/mbpc_pkg.sv @@
package mbpc_pkg;

  // Fixed field widths.
  localparam int unsigned LinesW     = 32;
  localparam int unsigned ThrW       = 15;
  localparam int unsigned TickW      = 16;
  localparam int unsigned BtnIdxW    = 4;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned MaxButtons = 4;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgMask0    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMask3    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDebounce = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLong     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRelease  = 3'd6;

  // Reset values of the thresholds.
  localparam logic [ThrW-1:0] DebounceRst = 15'd3;
  localparam logic [ThrW-1:0] LongRst     = 15'd100;
  localparam logic [ThrW-1:0] ReleaseRst  = 15'd3;

  // Item kinds.
  localparam logic FuncTick = 1'b0;
  localparam logic FuncRead = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_SHORT    = 3'd2,
    PH_LONG     = 3'd3,
    PH_RELEASE  = 3'd4,
    PH_HOLD     = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    RES_NONE    = 2'd0,
    RES_NOPRESS = 2'd1,
    RES_SHORT   = 2'd2,
    RES_LONG    = 2'd3
  } result_e;

endpackage

@@ rtl/multi_button_press_classifier.sv @@
// Short/long press classifier for up to four buttons that share one 32-bit map
// of raw key lines. A tick beat (func_i = 0) advances every button whose mask
// is nonzero through idle, debounce, short press, long press, release debounce
// and hold; a read beat (func_i = 1) returns one press_result_o beat for the
// named button and clears its result when the button is in the hold. The block
// takes one beat in every cycle: the per-button state registers are updated in
// the cycle a beat is accepted, and read results pass through a two-entry
// output buffer, so input stalls only when the consumer has stalled for two
// pending results. Each read result is registered in the head or the skid entry.
// Configuration writes take effect at the next clock edge.
module multi_button_press_classifier #(
  parameter int unsigned NUM_BUTTONS = mbpc_pkg::MaxButtons
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [mbpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mbpc_pkg::LinesW-1:0]   cfg_data_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [mbpc_pkg::LinesW-1:0]   pressed_lines_i,
  input  logic [mbpc_pkg::BtnIdxW-1:0]  button_index_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    press_result_o
);
  import mbpc_pkg::*;

  // Configuration registers.
  logic [LinesW-1:0] mask_q [NUM_BUTTONS];
  logic [ThrW-1:0]   debounce_q, long_q, release_q;

  // Per-button state.
  phase_e           phase_q  [NUM_BUTTONS];
  phase_e           phase_d  [NUM_BUTTONS];
  logic [TickW-1:0] ticks_q  [NUM_BUTTONS];
  logic [TickW-1:0] ticks_d  [NUM_BUTTONS];
  result_e          result_q [NUM_BUTTONS];
  result_e          result_d [NUM_BUTTONS];

  // Output buffer: head register and skid entry.
  logic    out_valid_q, skid_valid_q;
  result_e out_q, skid_q;

  logic    in_acc, tick_acc, read_acc, pop;
  result_e rd_res;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (func_i == FuncTick);
  assign read_acc   = in_acc && (func_i == FuncRead);
  assign pop        = out_valid_q && !out_stall_i;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUTTONS; b++) mask_q[b] <= '0;
      debounce_q <= DebounceRst;
      long_q     <= LongRst;
      release_q  <= ReleaseRst;
    end else if (cfg_we_i) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (cfg_index_i == CfgMask0 + CfgIdxW'(b)) mask_q[b] <= cfg_data_i;
      end
      case (cfg_index_i)
        CfgDebounce: debounce_q <= cfg_data_i[ThrW-1:0];
        CfgLong:     long_q     <= cfg_data_i[ThrW-1:0];
        CfgRelease:  release_q  <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Next state of every button, and the read result.
  always_comb begin
    logic             down;
    logic [TickW-1:0] inc;
    rd_res = RES_NONE;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      phase_d[b]  = phase_q[b];
      ticks_d[b]  = ticks_q[b];
      result_d[b] = result_q[b];
      down = |(pressed_lines_i & mask_q[b]);
      inc  = (ticks_q[b] == '1) ? ticks_q[b] : ticks_q[b] + TickW'(1);
      if (tick_acc && (mask_q[b] != '0)) begin
        case (phase_q[b])
          PH_DEBOUNCE: begin
            if (down) begin
              ticks_d[b]  = inc;
              result_d[b] = RES_SHORT;
              if (ticks_q[b] >= {1'b0, debounce_q}) phase_d[b] = PH_SHORT;
            end else begin
              phase_d[b] = PH_IDLE;
            end
          end
          PH_SHORT: begin
            if (down) begin
              ticks_d[b] = inc;
              if (ticks_q[b] >= {1'b0, long_q}) begin
                phase_d[b]  = PH_LONG;
                result_d[b] = RES_LONG;
              end
            end else begin
              phase_d[b] = PH_RELEASE;
              ticks_d[b] = '0;
            end
          end
          PH_LONG: begin
            if (!down) begin
              phase_d[b] = PH_RELEASE;
              ticks_d[b] = '0;
            end
          end
          PH_RELEASE: begin
            if (!down) begin
              ticks_d[b] = inc;
              if (ticks_q[b] >= {1'b0, release_q}) phase_d[b] = PH_HOLD;
            end
          end
          PH_HOLD: begin
            if (result_q[b] == RES_NONE) phase_d[b] = PH_IDLE;
          end
          default: begin
            // Idle, and any stray code, waits for a press.
            if (down) begin
              phase_d[b]  = PH_DEBOUNCE;
              ticks_d[b]  = '0;
              result_d[b] = RES_NOPRESS;
            end
          end
        endcase
      end
      // A read of a held button returns its result and clears it.
      if (read_acc && (button_index_i == BtnIdxW'(b)) && (phase_q[b] == PH_HOLD)) begin
        rd_res      = result_q[b];
        result_d[b] = RES_NONE;
      end
    end
  end

  // Button state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        phase_q[b]  <= PH_IDLE;
        ticks_q[b]  <= '0;
        result_q[b] <= RES_NONE;
      end
    end else begin
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        phase_q[b]  <= phase_d[b];
        ticks_q[b]  <= ticks_d[b];
        result_q[b] <= result_d[b];
      end
    end
  end

  // Output buffer control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= read_acc;
      end else begin
        out_valid_q  <= read_acc;
      end
    end else if (read_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output buffer data.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= rd_res;
      end else begin
        out_q  <= rd_res;
      end
    end else if (read_acc) begin
      skid_q <= rd_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign press_result_o = out_q;

  // The skid entry is only used behind a full head register.
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while output register is empty");

  // A read accepted with the output free shows up in the next cycle.
  a_read_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_acc && !out_valid_q) |=> out_valid_o)
    else $error("read beat did not reach the output");

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_chk
    // A long press always carries the long result.
    a_long_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (phase_q[g] == PH_LONG) |-> (result_q[g] == RES_LONG))
      else $error("long press phase without long result");

    // Debounce and short press always hold a pending result.
    a_active_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ((phase_q[g] == PH_DEBOUNCE) || (phase_q[g] == PH_SHORT))
        |-> (result_q[g] != RES_NONE))
      else $error("active press phase with no result");
  end

endmodule

@@ dv/mbpc_tb_pkg.sv @@
`timescale 1ns / 1ps

package mbpc_tb_pkg;

  import mbpc_pkg::*;

  // Scoreboard for the press classifier. It keeps its own copy of the
  // per-button state and registers, predicts the press result of each read
  // beat, and compares the results that leave the block in order.
  class press_scoreboard;

    logic [LinesW-1:0] btn_mask [MaxButtons];
    logic [ThrW-1:0]   debounce_thr;
    logic [ThrW-1:0]   long_thr;
    logic [ThrW-1:0]   release_thr;

    phase_e            btn_phase  [MaxButtons];
    logic [TickW-1:0]  btn_ticks  [MaxButtons];
    result_e           btn_result [MaxButtons];

    result_e           expected_press_q [$];
    int unsigned       mismatches;

    function new();
      for (int b = 0; b < MaxButtons; b++) begin
        btn_mask[b]   = '0;
        btn_phase[b]  = PH_IDLE;
        btn_ticks[b]  = '0;
        btn_result[b] = RES_NONE;
      end
      debounce_thr = DebounceRst;
      long_thr     = LongRst;
      release_thr  = ReleaseRst;
      mismatches   = 0;
    endfunction

    // Register writes keep only the bits that the register holds.
    function void write_register(logic [CfgIdxW-1:0] idx, logic [LinesW-1:0] data);
      if (idx <= CfgMask3) begin
        btn_mask[idx] = data;
      end else if (idx == CfgDebounce) begin
        debounce_thr = data[ThrW-1:0];
      end else if (idx == CfgLong) begin
        long_thr = data[ThrW-1:0];
      end else if (idx == CfgRelease) begin
        release_thr = data[ThrW-1:0];
      end
    endfunction

    // Compare the old count with the threshold, then count up with saturation.
    function bit count_hit(int b, logic [ThrW-1:0] thr);
      logic [TickW-1:0] prev;
      prev = btn_ticks[b];
      if (prev != '1) begin
        btn_ticks[b] = prev + 1'b1;
      end
      return prev >= {1'b0, thr};
    endfunction

    // One tick moves every button with a nonzero mask along its sequence.
    function void step_buttons(logic [LinesW-1:0] lines);
      bit down;
      for (int b = 0; b < MaxButtons; b++) begin
        if (btn_mask[b] == '0) continue;
        down = |(lines & btn_mask[b]);
        case (btn_phase[b])
          PH_DEBOUNCE: begin
            if (down) begin
              if (count_hit(b, debounce_thr)) btn_phase[b] = PH_SHORT;
              btn_result[b] = RES_SHORT;
            end else begin
              btn_phase[b] = PH_IDLE;
            end
          end
          PH_SHORT: begin
            if (down) begin
              if (count_hit(b, long_thr)) begin
                btn_phase[b]  = PH_LONG;
                btn_result[b] = RES_LONG;
              end
            end else begin
              btn_phase[b] = PH_RELEASE;
              btn_ticks[b] = '0;
            end
          end
          PH_LONG: begin
            if (!down) begin
              btn_phase[b] = PH_RELEASE;
              btn_ticks[b] = '0;
            end
          end
          PH_RELEASE: begin
            if (!down) begin
              if (count_hit(b, release_thr)) btn_phase[b] = PH_HOLD;
            end
          end
          PH_HOLD: begin
            if (btn_result[b] == RES_NONE) btn_phase[b] = PH_IDLE;
          end
          default: begin
            if (down) begin
              btn_phase[b]  = PH_DEBOUNCE;
              btn_ticks[b]  = '0;
              btn_result[b] = RES_NOPRESS;
            end
          end
        endcase
      end
    endfunction

    // Called for every beat the block accepts on its input.
    function void apply_beat(logic func, logic [LinesW-1:0] lines,
                             logic [BtnIdxW-1:0] idx);
      result_e got;
      if (func == FuncRead) begin
        got = RES_NONE;
        if (idx < MaxButtons && btn_phase[idx] == PH_HOLD) begin
          got             = btn_result[idx];
          btn_result[idx] = RES_NONE;
        end
        expected_press_q.push_back(got);
      end else begin
        step_buttons(lines);
      end
    endfunction

    // Called for every beat the block delivers on its output.
    function void check_press(logic [1:0] got);
      result_e want;
      if (expected_press_q.size() == 0) begin
        if (mismatches < 10) $display("press result %0d arrived with none expected", got);
        mismatches++;
      end else begin
        want = expected_press_q.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("press result mismatch: expected %0d, got %0d", want, got);
          end
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_press_q.size();
    endfunction

  endclass

endpackage

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  import mbpc_pkg::*;
  import mbpc_tb_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused  = 3'd7;
  localparam int                 CycleLimit = 400000;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [LinesW-1:0]   cfg_data_i      = '0;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic                func_i          = FuncTick;
  logic [LinesW-1:0]   pressed_lines_i = '0;
  logic [BtnIdxW-1:0]  button_index_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [1:0]          press_result_o;

  press_scoreboard sb = new();

  // Both sides idle at random while this is set.
  bit idle_on     = 1'b1;
  // Asks the receiver for one long hold-off.
  bit rx_hold_req = 1'b0;
  int cycle_count = 0;

  multi_button_press_classifier u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .pressed_lines_i (pressed_lines_i),
    .button_index_i  (button_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .press_result_o  (press_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL multi_button_press_classifier");
      $finish;
    end
  end

  // Every result beat is checked against the oldest predicted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_press(press_result_o);
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin : rx_side
    int gap;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 1'b0;
        rx_hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        gap = $urandom_range(1, 12);
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one beat, possibly after an idle burst, and wait until it is taken.
  task automatic send_beat(logic f, logic [LinesW-1:0] lines, logic [BtnIdxW-1:0] idx);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    pressed_lines_i <= lines;
    button_index_i  <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.apply_beat(f, lines, idx);
  endtask

  // The field that a beat kind does not use carries random bits.
  task automatic tick(logic [LinesW-1:0] lines);
    logic [BtnIdxW-1:0] junk;
    junk = BtnIdxW'($urandom);
    send_beat(FuncTick, lines, junk);
  endtask

  task automatic read_btn(logic [BtnIdxW-1:0] idx);
    send_beat(FuncRead, $urandom, idx);
  endtask

  // Stop offering beats and wait until every predicted result has arrived.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all registers, plus the unused index, with random bits above the
  // threshold width so that the register width is exercised.
  task automatic set_config(logic [MaxButtons-1:0][LinesW-1:0] masks,
                            logic [ThrW-1:0] deb, logic [ThrW-1:0] lng,
                            logic [ThrW-1:0] rel);
    logic [LinesW-1:0]  regs [8];
    logic [CfgIdxW-1:0] ri;
    for (int b = 0; b < MaxButtons; b++) regs[CfgMask0 + b] = masks[b];
    regs[CfgDebounce] = ($urandom & 32'hFFFF_8000) | deb;
    regs[CfgLong]     = ($urandom & 32'hFFFF_8000) | lng;
    regs[CfgRelease]  = ($urandom & 32'hFFFF_8000) | rel;
    regs[CfgUnused]   = $urandom;
    for (int i = 0; i <= CfgUnused; i++) begin
      ri = CfgIdxW'(i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= ri;
      cfg_data_i  <= regs[i];
      @(posedge clk_i);
      sb.write_register(ri, regs[i]);
    end
    cfg_we_i <= 1'b0;
    repeat (2) @(posedge clk_i);
  endtask

  function automatic logic [LinesW-1:0] rand_mask();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
    endcase
  endfunction

  // Small thresholds so that random sequences run all the way to the hold.
  task automatic random_config(bit zero_thr);
    logic [MaxButtons-1:0][LinesW-1:0] masks;
    for (int b = 0; b < MaxButtons; b++) masks[b] = rand_mask();
    if (zero_thr) begin
      set_config(masks, '0, '0, '0);
    end else begin
      set_config(masks, ThrW'($urandom_range(0, 4)), ThrW'($urandom_range(0, 15)),
                 ThrW'($urandom_range(0, 4)));
    end
  endtask

  function automatic logic [LinesW-1:0] pick_lines();
    case ($urandom_range(0, 5))
      0, 1:    return '0;
      2:       return sb.btn_mask[$urandom_range(0, MaxButtons - 1)];
      3:       return sb.btn_mask[$urandom_range(0, MaxButtons - 1)]
                    | sb.btn_mask[$urandom_range(0, MaxButtons - 1)];
      4:       return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // Mostly held key patterns of random length, so presses pass debounce and
  // reach long press, mixed with reads and single-tick glitches.
  task automatic run_random(int n_items);
    logic [LinesW-1:0]  held;
    logic [BtnIdxW-1:0] idx;
    int                 run_left;
    held     = '0;
    run_left = 0;
    for (int k = 0; k < n_items; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 7) == 0) idx = BtnIdxW'($urandom);
          else idx = BtnIdxW'($urandom_range(0, MaxButtons - 1));
          read_btn(idx);
        end
        3: tick($urandom);
        default: begin
          if (run_left == 0) begin
            held     = pick_lines();
            run_left = $urandom_range(1, 24);
          end
          run_left--;
          tick(held);
        end
      endcase
    end
  endtask

  // Bring every button back to idle with short thresholds kept.
  task automatic park_buttons();
    set_config('1, sb.debounce_thr, sb.long_thr, sb.release_thr);
    repeat (20) tick('0);
    for (int b = 0; b < MaxButtons; b++) read_btn(BtnIdxW'(b));
    tick('0);
    wait_idle();
  endtask

  initial begin : stimulus
    logic [MaxButtons-1:0][LinesW-1:0] masks;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reads before any button is in the hold, and a tick with no button used.
    read_btn(0);
    read_btn(15);
    tick('1);
    read_btn(3);
    wait_idle();

    masks    = '0;
    masks[0] = 32'h0000_0001;
    masks[1] = 32'h8000_0000;
    masks[2] = '1;
    set_config(masks, ThrW'(0), ThrW'(1), ThrW'(0));

    // Short press, a press during release debounce, and reading twice.
    tick(32'h1);
    tick(32'h1);
    tick('0);
    tick(32'h1);
    read_btn(0);
    tick('0);
    read_btn(0);
    read_btn(0);
    read_btn(2);
    tick('0);

    // Long press, then a read of the first index past the buttons.
    tick(32'h8000_0000);
    tick(32'h8000_0000);
    tick(32'h8000_0000);
    tick('0);
    tick('0);
    read_btn(1);
    read_btn(2);
    read_btn(4);

    // A press that bounces out of debounce.
    tick(32'h1);
    tick('0);
    read_btn(0);
    wait_idle();

    // Random phases, each with its own registers; one with a long hold-off.
    for (int p = 0; p < 5; p++) begin
      random_config(p == 0);
      if (p == 2) begin
        rx_hold_req = 1'b1;
        for (int k = 0; k < 30; k++) read_btn(BtnIdxW'($urandom_range(0, MaxButtons - 1)));
      end
      run_random(70);
      wait_idle();
    end

    // The last part runs without idling.
    idle_on = 1'b0;
    park_buttons();

    // Largest thresholds: a held press stays in debounce and is never ready.
    masks    = '0;
    masks[0] = '1;
    set_config(masks, '1, '1, '1);
    for (int k = 0; k < 24; k++) begin
      if (k == 12) read_btn(0);
      tick($urandom | (32'd1 << $urandom_range(0, 31)));
    end
    tick('0);
    read_btn(0);
    read_btn(0);
    tick('0);
    wait_idle();

    random_config(1'b0);
    run_random(70);
    wait_idle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS multi_button_press_classifier");
    end else begin
      $display("FAIL multi_button_press_classifier");
    end
    $finish;
  end

endmodule
